FILE: sv/cbph_pkg.sv
`timescale 1ns / 1ps
package cbph_pkg;

	localparam int COORD_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int T_BITS           = 16;
	localparam int HEAD_BITS        = 16;
	// CORDIC datapath word and angle accumulator widths
	localparam int CW               = 64;
	localparam int AW               = 34;
	// normalise until a component reaches 2^NORM_EXP
	localparam int NORM_EXP         = 57;
	localparam int NORM_STAGES      = 7;
	// tangent pipeline depth and normaliser depth (shift stages plus quadrant stage)
	localparam int TAN_LAT          = 2;
	localparam int NORM_LAT         = NORM_STAGES + 1;
	localparam int POINT_LAT        = 3;

	// atan(2^-i) in units of pi / 2^31
	function automatic logic signed [AW-1:0] atan_units(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0:  r = AW'(536870912);
			1:  r = AW'(316933406);
			2:  r = AW'(167458907);
			3:  r = AW'(85004756);
			4:  r = AW'(42667331);
			5:  r = AW'(21354465);
			6:  r = AW'(10679838);
			7:  r = AW'(5340245);
			8:  r = AW'(2670163);
			9:  r = AW'(1335087);
			10: r = AW'(667544);
			11: r = AW'(333772);
			12: r = AW'(166886);
			13: r = AW'(83443);
			14: r = AW'(41722);
			15: r = AW'(20861);
			16: r = AW'(10430);
			17: r = AW'(5215);
			18: r = AW'(2608);
			19: r = AW'(1304);
			20: r = AW'(652);
			21: r = AW'(326);
			22: r = AW'(163);
			23: r = AW'(81);
			24: r = AW'(41);
			25: r = AW'(20);
			26: r = AW'(10);
			27: r = AW'(5);
			28: r = AW'(3);
			29: r = AW'(1);
			30: r = AW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// shift tried at each normaliser stage: 32,16,8,4,2,1 then a final 1
	function automatic int norm_shift(input int k);
		return (k < NORM_STAGES - 1) ? (32 >> k) : 1;
	endfunction

	function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
		return v[CW-1] ? CW'(-v) : CW'(v);
	endfunction

endpackage

FILE: sv/cbph_lerp.sv
`timescale 1ns / 1ps
// De Casteljau triangle for one axis, one round of lerps per stage
module cbph_lerp #(
	parameter int CB = cbph_pkg::COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [15:0]          t,
	input  logic signed [CB-1:0] c0,
	input  logic signed [CB-1:0] c1,
	input  logic signed [CB-1:0] c2,
	input  logic signed [CB-1:0] c3,
	output logic signed [CB-1:0] p
);

	// a + floor(((b-a)*t + 32768) / 65536)
	function automatic logic signed [CB-1:0] lerp(input logic signed [CB-1:0] a,
			input logic signed [CB-1:0] b, input logic [15:0] tv);
		logic signed [CB:0]    d;
		logic signed [CB+17:0] pr;
		logic signed [CB+17:0] q;
		d  = {b[CB-1], b} - {a[CB-1], a};
		pr = d * $signed({1'b0, tv});
		q  = (pr + (CB+18)'(32768)) >>> 16;
		return a + q[CB-1:0];
	endfunction

	logic signed [CB-1:0] w_s1 [0:2];
	logic [15:0]          t_s1;
	logic signed [CB-1:0] w_s2 [0:1];
	logic [15:0]          t_s2;
	logic signed [CB-1:0] p_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1[0] <= lerp(c0, c1, t);
			w_s1[1] <= lerp(c1, c2, t);
			w_s1[2] <= lerp(c2, c3, t);
			t_s1    <= t;
			w_s2[0] <= lerp(w_s1[0], w_s1[1], t_s1);
			w_s2[1] <= lerp(w_s1[1], w_s1[2], t_s1);
			t_s2    <= t_s1;
			p_s3    <= lerp(w_s2[0], w_s2[1], t_s2);
		end
	end

	assign p = p_s3;

endmodule

FILE: sv/cbph_tan.sv
`timescale 1ns / 1ps
// Tangent: quadratic Bezier of the control point differences, exact up to 28-bit coordinates
module cbph_tan #(
	parameter int CB = cbph_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [15:0]                       t,
	input  logic signed [CB-1:0]              cx [0:3],
	input  logic signed [CB-1:0]              cy [0:3],
	output logic signed [cbph_pkg::CW-1:0]    gx,
	output logic signed [cbph_pkg::CW-1:0]    gy
);

	localparam int TS = (CB > 28) ? CB - 28 : 0;
	localparam int EW = CB + 19 - TS;

	// d0*u + d1*t from three control points, scaled down for wide coordinates
	function automatic logic signed [EW-1:0] e_of(input logic signed [CB-1:0] a,
			input logic signed [CB-1:0] b, input logic signed [CB-1:0] c,
			input logic [16:0] u, input logic [15:0] tv);
		logic signed [CB:0]    d0;
		logic signed [CB:0]    d1;
		logic signed [CB+18:0] er;
		logic signed [CB+18:0] sh;
		d0 = {b[CB-1], b} - {a[CB-1], a};
		d1 = {c[CB-1], c} - {b[CB-1], b};
		er = d0 * $signed({1'b0, u}) + d1 * $signed({1'b0, tv});
		sh = er >>> TS;
		return sh[EW-1:0];
	endfunction

	logic [16:0]          u_in;
	logic signed [EW-1:0] ex_s1 [0:1];
	logic signed [EW-1:0] ey_s1 [0:1];
	logic [16:0]          u_s1;
	logic [15:0]          t_s1;
	logic signed [cbph_pkg::CW-1:0] gx_s2;
	logic signed [cbph_pkg::CW-1:0] gy_s2;

	assign u_in = 17'd65536 - {1'b0, t};

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1[0] <= e_of(cx[0], cx[1], cx[2], u_in, t);
			ex_s1[1] <= e_of(cx[1], cx[2], cx[3], u_in, t);
			ey_s1[0] <= e_of(cy[0], cy[1], cy[2], u_in, t);
			ey_s1[1] <= e_of(cy[1], cy[2], cy[3], u_in, t);
			u_s1     <= u_in;
			t_s1     <= t;
			gx_s2    <= ex_s1[0] * $signed({1'b0, u_s1}) + ex_s1[1] * $signed({2'b0, t_s1});
			gy_s2    <= ey_s1[0] * $signed({1'b0, u_s1}) + ey_s1[1] * $signed({2'b0, t_s1});
		end
	end

	assign gx = gx_s2;
	assign gy = gy_s2;

endmodule

FILE: sv/cbph_norm.sv
`timescale 1ns / 1ps
// Normaliser: vector (-gx, gy) scaled up by a binary shift search, then folded
// into the right half plane with a starting angle of +-pi
module cbph_norm (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [cbph_pkg::CW-1:0] gx,
	input  logic signed [cbph_pkg::CW-1:0] gy,
	output logic signed [cbph_pkg::CW-1:0] x,
	output logic signed [cbph_pkg::CW-1:0] y,
	output logic signed [cbph_pkg::AW-1:0] acc,
	output logic                           zero
);

	localparam int NS = cbph_pkg::NORM_STAGES;
	localparam int CW = cbph_pkg::CW;
	localparam int AW = cbph_pkg::AW;

	logic signed [CW-1:0] nx_s [0:NS];
	logic signed [CW-1:0] ny_s [0:NS];
	logic                 nz_s [0:NS];
	logic signed [CW-1:0] xo_s;
	logic signed [CW-1:0] yo_s;
	logic signed [AW-1:0] acc_s;
	logic                 zo_s;

	assign nx_s[0] = -gx;
	assign ny_s[0] = gy;
	assign nz_s[0] = (gx == '0) && (gy == '0);

	// one trial shift per stage; the search stages keep the larger component
	// below 2^NORM_EXP, the last stage lifts it to 2^NORM_EXP or above
	for (genvar k = 0; k < NS; k++) begin : g_shift
		localparam int K = cbph_pkg::norm_shift(k);
		localparam int E = (k < NS - 1) ? cbph_pkg::NORM_EXP - K : cbph_pkg::NORM_EXP;
		logic [CW-1:0] m;
		logic          go;
		assign m  = cbph_pkg::mag(nx_s[k]) | cbph_pkg::mag(ny_s[k]);
		assign go = (m >> E) == '0;
		always_ff @(posedge clk) begin
			if (en) begin
				nx_s[k+1] <= go ? (nx_s[k] <<< K) : nx_s[k];
				ny_s[k+1] <= go ? (ny_s[k] <<< K) : ny_s[k];
				nz_s[k+1] <= nz_s[k];
			end
		end
	end

	// left half plane: negate and start from +pi or -pi
	always_ff @(posedge clk) begin
		if (en) begin
			if (nx_s[NS][CW-1]) begin
				xo_s  <= -nx_s[NS];
				yo_s  <= -ny_s[NS];
				acc_s <= ny_s[NS][CW-1] ? -(AW'(1) <<< 31) : (AW'(1) <<< 31);
			end else begin
				xo_s  <= nx_s[NS];
				yo_s  <= ny_s[NS];
				acc_s <= '0;
			end
			zo_s <= nz_s[NS];
		end
	end

	assign x    = xo_s;
	assign y    = yo_s;
	assign acc  = acc_s;
	assign zero = zo_s;

endmodule

FILE: sv/cbph_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC, one rotation per stage
module cbph_cordic #(
	parameter int STEPS = cbph_pkg::CORDIC_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [cbph_pkg::CW-1:0] x,
	input  logic signed [cbph_pkg::CW-1:0] y,
	input  logic signed [cbph_pkg::AW-1:0] acc,
	output logic signed [cbph_pkg::AW-1:0] angle
);

	localparam int CW = cbph_pkg::CW;
	localparam int AW = cbph_pkg::AW;

	logic signed [CW-1:0] cx_s [0:STEPS];
	logic signed [CW-1:0] cy_s [0:STEPS];
	logic signed [AW-1:0] ca_s [0:STEPS];

	assign cx_s[0] = x;
	assign cy_s[0] = y;
	assign ca_s[0] = acc;

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		localparam logic signed [AW-1:0] A = cbph_pkg::atan_units(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[i][CW-1]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					ca_s[i+1] <= ca_s[i] - A;
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					ca_s[i+1] <= ca_s[i] + A;
				end
			end
		end
	end

	assign angle = ca_s[STEPS];

endmodule

FILE: sv/cubic_bezier_point_and_heading.sv
`timescale 1ns / 1ps
// Cubic Bezier point and heading. Each item (t and four control points) gives
// the curve point by de Casteljau interpolation and the tangent heading
// atan2(dy, -dx) in units of pi/32768, with tangent_zero set and heading 0
// when the tangent vanishes. Fully pipelined: one item per cycle while the
// output is not stalled, through 2 tangent multiply stages, 8 normaliser stages,
// one stage per CORDIC rotation and one output stage. The whole pipeline holds
// while out_valid is high and out_ready is low.
module cubic_bezier_point_and_heading #(
	parameter int COORD_BITS   = cbph_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STEPS = cbph_pkg::CORDIC_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [15:0]                  t_value,
	input  logic signed [COORD_BITS-1:0] ctrl0_x,
	input  logic signed [COORD_BITS-1:0] ctrl0_y,
	input  logic signed [COORD_BITS-1:0] ctrl1_x,
	input  logic signed [COORD_BITS-1:0] ctrl1_y,
	input  logic signed [COORD_BITS-1:0] ctrl2_x,
	input  logic signed [COORD_BITS-1:0] ctrl2_y,
	input  logic signed [COORD_BITS-1:0] ctrl3_x,
	input  logic signed [COORD_BITS-1:0] ctrl3_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic signed [15:0]           heading,
	output logic                         tangent_zero
);

	localparam int CW  = cbph_pkg::CW;
	localparam int AW  = cbph_pkg::AW;
	localparam int LAT = cbph_pkg::TAN_LAT + cbph_pkg::NORM_LAT + CORDIC_STEPS + 1;
	localparam int PD  = LAT - cbph_pkg::POINT_LAT;

	logic                         adv;
	logic [LAT-1:0]               v_q;
	logic signed [COORD_BITS-1:0] cx [0:3];
	logic signed [COORD_BITS-1:0] cy [0:3];
	logic signed [COORD_BITS-1:0] px;
	logic signed [COORD_BITS-1:0] py;
	logic signed [CW-1:0]         gx;
	logic signed [CW-1:0]         gy;
	logic signed [CW-1:0]         nx;
	logic signed [CW-1:0]         ny;
	logic signed [AW-1:0]         nacc;
	logic                         nzero;
	logic signed [AW-1:0]         angle;
	logic signed [AW-1:0]         rnd;
	logic signed [COORD_BITS-1:0] px_d [0:PD-1];
	logic signed [COORD_BITS-1:0] py_d [0:PD-1];
	logic                         z_d  [0:CORDIC_STEPS];
	logic signed [15:0]           heading_s;

	// global advance: the pipeline moves unless a finished item is held
	assign adv      = !v_q[LAT-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	assign cx = '{ctrl0_x, ctrl1_x, ctrl2_x, ctrl3_x};
	assign cy = '{ctrl0_y, ctrl1_y, ctrl2_y, ctrl3_y};

	cbph_lerp #(.CB(COORD_BITS)) u_lerp_x (
		.clk(clk), .en(adv), .t(t_value),
		.c0(ctrl0_x), .c1(ctrl1_x), .c2(ctrl2_x), .c3(ctrl3_x), .p(px)
	);

	cbph_lerp #(.CB(COORD_BITS)) u_lerp_y (
		.clk(clk), .en(adv), .t(t_value),
		.c0(ctrl0_y), .c1(ctrl1_y), .c2(ctrl2_y), .c3(ctrl3_y), .p(py)
	);

	cbph_tan #(.CB(COORD_BITS)) u_tan (
		.clk(clk), .en(adv), .t(t_value), .cx(cx), .cy(cy), .gx(gx), .gy(gy)
	);

	cbph_norm u_norm (
		.clk(clk), .en(adv), .gx(gx), .gy(gy),
		.x(nx), .y(ny), .acc(nacc), .zero(nzero)
	);

	cbph_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .en(adv), .x(nx), .y(ny), .acc(nacc), .angle(angle)
	);

	// point and zero flag ride alongside the heading path
	always_ff @(posedge clk) begin
		if (adv) begin
			px_d[0] <= px;
			py_d[0] <= py;
			for (int k = 1; k < PD; k++) begin
				px_d[k] <= px_d[k-1];
				py_d[k] <= py_d[k-1];
			end
			z_d[0] <= nzero;
			for (int k = 1; k <= CORDIC_STEPS; k++) begin
				z_d[k] <= z_d[k-1];
			end
		end
	end

	// round half up to pi/2^15 and wrap to 16 bits
	assign rnd = angle + AW'(32768);

	always_ff @(posedge clk) begin
		if (adv) begin
			heading_s <= z_d[CORDIC_STEPS-1] ? '0 : rnd[31:16];
		end
	end

	assign out_valid    = v_q[LAT-1];
	assign point_x      = px_d[PD-1];
	assign point_y      = py_d[PD-1];
	assign heading      = heading_s;
	assign tangent_zero = z_d[CORDIC_STEPS];

	a_zero_heading : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tangent_zero |-> heading == '0)
		else $error("zero tangent with nonzero heading");

	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> v_q == $past(v_q))
		else $error("pipeline moved during stall");

	a_no_take_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while output held");

endmodule
